/* sv/dllm_pkg.sv */
// Shared types and constants of the doubly linked list manager.
package dllm_pkg;

	localparam int IDX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int REQ_W    = 4;
	localparam int IDX_SPAN = 1 << IDX_W;

	localparam int S_DATA_W = 32;
	localparam int S_USER_W = REQ_W;
	localparam int M_DATA_W = 40;

	// Request payload positions in s_axis_tdata.
	localparam int S_NODE_LSB  = 0;
	localparam int S_REF_LSB   = S_NODE_LSB + IDX_W;
	localparam int S_COUNT_LSB = S_REF_LSB + IDX_W;

	// Result payload positions in m_axis_tdata.
	localparam int M_STATUS_BIT  = 0;
	localparam int M_FVALID_BIT  = 1;
	localparam int M_FOUND_LSB   = 2;
	localparam int M_COUNT_LSB   = M_FOUND_LSB + IDX_W;
	localparam int M_HVALID_BIT  = M_COUNT_LSB + CNT_W;
	localparam int M_HEAD_LSB    = M_HVALID_BIT + 1;
	localparam int M_TAIL_LSB    = M_HEAD_LSB + IDX_W;
	localparam int M_USED_W      = M_TAIL_LSB + IDX_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND     = 4'd0,
		REQ_INS_HEAD   = 4'd1,
		REQ_INS_BEFORE = 4'd2,
		REQ_DELETE     = 4'd3,
		REQ_DEL_HEAD   = 4'd4,
		REQ_DEL_TAIL   = 4'd5,
		REQ_NEXT       = 4'd6,
		REQ_PREV       = 4'd7,
		REQ_CLEAR      = 4'd8,
		REQ_LOAD       = 4'd9
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_STEP2,
		ST_STEP3,
		ST_LOAD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_NODE,
		RD_REF,
		RD_HEAD,
		RD_TAIL
	} rd_sel_t;

	typedef enum logic [3:0] {
		W_NONE,
		W_APP_LINK,
		W_APP_NODE,
		W_INSH_LINK,
		W_INSH_NODE,
		W_INSB_NODE,
		W_INSB_LINK,
		W_UNLINK,
		W_FOUND_NEXT,
		W_FOUND_PREV,
		W_CLEAR,
		W_LOAD
	} wcmd_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		wcmd_t   wcmd;
		logic    reject;
		logic    result_load;
	} ctrl_cmd_t;

	typedef struct packed {
		req_t op;
		logic empty;
		logic head_none;
		logic tail_none;
		logic load_done;
		logic out_free;
	} dp_stat_t;

endpackage

/* sv/dllm_ctrl.sv */
// Sequencing state machine of the doubly linked list manager.
module dllm_ctrl import dllm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_valid,
	output logic      s_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		s_ready         = 1'b0;
		cmd.capture     = 1'b0;
		cmd.rd_en       = 1'b0;
		cmd.rd_sel      = RD_NODE;
		cmd.wcmd        = W_NONE;
		cmd.reject      = 1'b0;
		cmd.result_load = 1'b0;

		case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_STEP2;
				case (stat.op)
					REQ_APPEND:   cmd.wcmd = W_APP_LINK;
					REQ_INS_HEAD: cmd.wcmd = W_INSH_LINK;
					REQ_INS_BEFORE: begin
						if (stat.empty) begin
							cmd.reject = 1'b1;
							state_d    = ST_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_REF;
						end
					end
					REQ_DELETE: begin
						if (stat.empty) begin
							cmd.reject = 1'b1;
							state_d    = ST_DONE;
						end else begin
							cmd.rd_en = 1'b1;
						end
					end
					REQ_DEL_HEAD: begin
						if (stat.empty || stat.head_none) begin
							cmd.reject = 1'b1;
							state_d    = ST_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_HEAD;
						end
					end
					REQ_DEL_TAIL: begin
						if (stat.empty || stat.tail_none) begin
							cmd.reject = 1'b1;
							state_d    = ST_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_TAIL;
						end
					end
					REQ_NEXT, REQ_PREV: cmd.rd_en = 1'b1;
					REQ_CLEAR: begin
						cmd.wcmd = W_CLEAR;
						state_d  = ST_DONE;
					end
					REQ_LOAD: begin
						cmd.wcmd = W_CLEAR;
						state_d  = ST_LOAD;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_STEP2: begin
				state_d = ST_DONE;
				case (stat.op)
					REQ_APPEND:   cmd.wcmd = W_APP_NODE;
					REQ_INS_HEAD: cmd.wcmd = W_INSH_NODE;
					REQ_INS_BEFORE: begin
						cmd.wcmd = W_INSB_NODE;
						state_d  = ST_STEP3;
					end
					REQ_DELETE, REQ_DEL_HEAD, REQ_DEL_TAIL: cmd.wcmd = W_UNLINK;
					REQ_NEXT: cmd.wcmd = W_FOUND_NEXT;
					REQ_PREV: cmd.wcmd = W_FOUND_PREV;
					default:  cmd.wcmd = W_NONE;
				endcase
			end
			ST_STEP3: begin
				cmd.wcmd = W_INSB_LINK;
				state_d  = ST_DONE;
			end
			ST_LOAD: begin
				if (stat.load_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.wcmd = W_LOAD;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* sv/dllm_dp.sv */
// Datapath of the doubly linked list manager: link memories, list registers, result register.
module dllm_dp import dllm_pkg::*; #(
	parameter int POOL_NODES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [S_USER_W-1:0] s_tuser,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int PW = $clog2(POOL_NODES + 1);
	localparam int CW = (PW > CNT_W) ? PW : CNT_W;
	localparam logic [PW-1:0] NONE = PW'(POOL_NODES);

	function automatic logic is_node(input logic [PW-1:0] p);
		return p < NONE;
	endfunction

	// Reduction of an 8-bit index into the pool, worked out at elaboration.
	logic [IDX_W-1:0] mod_tab [IDX_SPAN];
	for (genvar gi = 0; gi < IDX_SPAN; gi++) begin : g_mod
		localparam int unsigned MODV = gi % POOL_NODES;
		assign mod_tab[gi] = IDX_W'(MODV);
	end

	logic [PW-1:0] next_mem [POOL_NODES];
	logic [PW-1:0] prev_mem [POOL_NODES];

	req_t             op_q;
	logic [PW-1:0]    n_q, r_q, k_q, i_q;
	logic [PW-1:0]    head_q, tail_q, found_q;
	logic [CNT_W-1:0] count_q;
	logic             status_q;
	logic [PW-1:0]    next_rd_q, prev_rd_q;
	logic             out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic [PW-1:0]    head_d, tail_d, found_d, i_d;
	logic [CNT_W-1:0] count_d;
	logic             status_d;
	logic             nw_en, pw_en;
	logic [AW-1:0]    nw_addr, pw_addr, rd_addr;
	logic [PW-1:0]    nw_data, pw_data, rd_ptr;
	logic [PW:0]      i_plus;
	logic             empty;
	logic [CW-1:0]    bc_ext;
	logic [M_DATA_W-1:0] out_next;

	assign empty  = (count_q == '0);
	assign i_plus = {1'b0, i_q} + {{PW{1'b0}}, 1'b1};
	assign bc_ext = CW'(s_tdata[S_COUNT_LSB +: CNT_W]);

	always_comb begin
		case (cmd.rd_sel)
			RD_NODE: rd_ptr = n_q;
			RD_REF:  rd_ptr = r_q;
			RD_HEAD: rd_ptr = head_q;
			RD_TAIL: rd_ptr = tail_q;
			default: rd_ptr = n_q;
		endcase
		rd_addr = rd_ptr[AW-1:0];
	end

	always_comb begin
		nw_en    = 1'b0;
		nw_addr  = '0;
		nw_data  = '0;
		pw_en    = 1'b0;
		pw_addr  = '0;
		pw_data  = '0;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		found_d  = found_q;
		status_d = status_q;
		i_d      = i_q;

		if (cmd.capture) begin
			found_d  = NONE;
			status_d = 1'b0;
			i_d      = '0;
		end
		if (cmd.reject) begin
			status_d = 1'b1;
		end

		case (cmd.wcmd)
			W_APP_LINK: begin
				if (!empty && is_node(tail_q)) begin
					nw_en   = 1'b1;
					nw_addr = tail_q[AW-1:0];
					nw_data = n_q;
				end
			end
			W_APP_NODE: begin
				nw_en   = 1'b1;
				nw_addr = n_q[AW-1:0];
				nw_data = NONE;
				pw_en   = 1'b1;
				pw_addr = n_q[AW-1:0];
				pw_data = tail_q;
				if (empty) begin
					head_d = n_q;
				end
				tail_d  = n_q;
				count_d = count_q + CNT_W'(1);
			end
			W_INSH_LINK: begin
				if (!empty && is_node(head_q)) begin
					pw_en   = 1'b1;
					pw_addr = head_q[AW-1:0];
					pw_data = n_q;
				end
			end
			W_INSH_NODE: begin
				nw_en   = 1'b1;
				nw_addr = n_q[AW-1:0];
				nw_data = head_q;
				pw_en   = 1'b1;
				pw_addr = n_q[AW-1:0];
				pw_data = NONE;
				if (empty) begin
					tail_d = n_q;
				end
				head_d  = n_q;
				count_d = count_q + CNT_W'(1);
			end
			W_INSB_NODE: begin
				nw_en   = 1'b1;
				nw_addr = n_q[AW-1:0];
				nw_data = r_q;
				pw_en   = 1'b1;
				pw_addr = n_q[AW-1:0];
				pw_data = prev_rd_q;
			end
			W_INSB_LINK: begin
				if (is_node(prev_rd_q)) begin
					nw_en   = 1'b1;
					nw_addr = prev_rd_q[AW-1:0];
					nw_data = n_q;
				end else begin
					head_d = n_q;
				end
				pw_en   = 1'b1;
				pw_addr = r_q[AW-1:0];
				pw_data = n_q;
				count_d = count_q + CNT_W'(1);
			end
			W_UNLINK: begin
				if (is_node(prev_rd_q)) begin
					nw_en   = 1'b1;
					nw_addr = prev_rd_q[AW-1:0];
					nw_data = next_rd_q;
				end else begin
					head_d = next_rd_q;
				end
				if (is_node(next_rd_q)) begin
					pw_en   = 1'b1;
					pw_addr = next_rd_q[AW-1:0];
					pw_data = prev_rd_q;
				end else begin
					tail_d = prev_rd_q;
				end
				count_d = count_q - CNT_W'(1);
				if (op_q == REQ_DELETE) begin
					found_d = next_rd_q;
				end else if (op_q == REQ_DEL_HEAD) begin
					found_d = head_q;
				end else begin
					found_d = tail_q;
				end
			end
			W_FOUND_NEXT: found_d = next_rd_q;
			W_FOUND_PREV: found_d = prev_rd_q;
			W_CLEAR: begin
				head_d  = NONE;
				tail_d  = NONE;
				count_d = '0;
				i_d     = '0;
			end
			W_LOAD: begin
				nw_en   = 1'b1;
				nw_addr = i_q[AW-1:0];
				nw_data = (i_plus < {1'b0, k_q}) ? i_plus[PW-1:0] : NONE;
				pw_en   = 1'b1;
				pw_addr = i_q[AW-1:0];
				pw_data = (i_q == '0) ? NONE : (i_q - PW'(1));
				i_d     = i_plus[PW-1:0];
				if (i_plus == {1'b0, k_q}) begin
					head_d  = '0;
					tail_d  = i_q;
					count_d = CNT_W'(k_q);
				end
			end
			default: ;
		endcase
	end

	// Link memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (nw_en) begin
			next_mem[nw_addr] <= nw_data;
		end
		if (pw_en) begin
			prev_mem[pw_addr] <= pw_data;
		end
		if (cmd.rd_en) begin
			next_rd_q <= next_mem[rd_addr];
			prev_rd_q <= prev_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= req_t'(s_tuser);
			n_q  <= PW'(mod_tab[s_tdata[S_NODE_LSB +: IDX_W]]);
			r_q  <= PW'(mod_tab[s_tdata[S_REF_LSB +: IDX_W]]);
			k_q  <= (bc_ext > CW'(POOL_NODES)) ? NONE : PW'(bc_ext);
		end
		i_q      <= i_d;
		found_q  <= found_d;
		status_q <= status_d;
		if (cmd.result_load) begin
			out_data_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NONE;
			tail_q      <= NONE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_next = '0;
		out_next[M_STATUS_BIT] = status_q;
		out_next[M_FVALID_BIT] = is_node(found_q);
		out_next[M_FOUND_LSB +: IDX_W] = is_node(found_q) ? IDX_W'(found_q) : '0;
		out_next[M_COUNT_LSB +: CNT_W] = count_q;
		out_next[M_HVALID_BIT] = is_node(head_q);
		out_next[M_HEAD_LSB +: IDX_W] = is_node(head_q) ? IDX_W'(head_q) : '0;
		out_next[M_TAIL_LSB +: IDX_W] = is_node(tail_q) ? IDX_W'(tail_q) : '0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign stat.op        = op_q;
	assign stat.empty     = empty;
	assign stat.head_none = !is_node(head_q);
	assign stat.tail_none = !is_node(tail_q);
	assign stat.load_done = (i_q == k_q);
	assign stat.out_free  = !out_valid_q || m_tready;

endmodule

/* sv/doubly_linked_list_manager.sv */
// Top level of the doubly linked list manager: controller plus datapath.
//
// Channel   Dir   Signals                  Payload
// s_axis    in    tvalid tready tdata tuser  one request transaction
// m_axis    out   tvalid tready tdata        one result transaction per request
//
// States per request after IDLE accepts it: append, insert at head, delete, delete
// head, delete tail, next and prev pass EXEC, STEP2 and DONE; insert before adds
// STEP3 ahead of DONE; clear, rejected requests and unused codes pass EXEC and DONE;
// load pool passes EXEC, LOAD once per appended node with a write to each link
// memory, and DONE. Each link memory has a registered read and a single write port.
// Reset clears head, tail, count and the result valid flag; link memories are not cleared.
// A result waiting in the output register stalls only the finishing step of the next request.
module doubly_linked_list_manager import dllm_pkg::*; #(
	parameter int POOL_NODES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// node_index [7:0], ref_index [15:8], block_count [24:16], zero [31:25]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// req_type [3:0]
	input  logic [S_USER_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// status [0], found_valid [1], found_index [9:2], item_count [18:10],
	// head_valid [19], head_index [27:20], tail_index [35:28], zero [39:36]
	output logic [M_DATA_W-1:0] m_axis_tdata
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The controller steps through each request and issues one datapath
	// command per cycle; the datapath reports the decoded request and the
	// list conditions the controller branches on.
	dllm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// The datapath holds the next and previous link memories, the head, tail
	// and count registers, and the result register that feeds m_axis.
	dllm_dp #(
		.POOL_NODES (POOL_NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.m_tready (m_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tdata  (m_axis_tdata)
	);

endmodule

/* sv/dllm_chk.sv */
// Port-level checker of the doubly linked list manager and its bind.
module dllm_chk import dllm_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata
);

	// A result not yet taken stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// One request is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in progress");

	// A new result only appears at the end of a request, never while idle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without a request in progress");

endmodule

bind doubly_linked_list_manager dllm_chk u_chk (.*);
